@@ hdl/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge while out of reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Same check, with a message of the caller's choosing.
`define CHK_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ hdl/cghr_pkg.sv @@
// Shared types, constants and the color ramp of the crossing grid heat map.
package cghr_pkg;

  localparam int unsigned LEVEL_W = 18;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COORD_W = 9;
  localparam int unsigned FIELD_W = 3;

  localparam logic [COLOR_W-1:0] ZERO_COLOR = 16'd31;
  localparam logic [15:0]        X_PITCH    = 16'd53;
  localparam logic [15:0]        Y_PITCH    = 16'd35;
  localparam logic [7:0]         RAMP_SCALE = 8'd188;
  localparam logic signed [LEVEL_W:0] FULL_SUM = 19'sd131072;

  typedef struct packed {
    logic load;
    logic issue;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic advance;
    logic k_last;
    logic pipe_empty;
    logic pend_valid;
  } sts_t;

  // packed so that cell_col lands in the low bits of the output word
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_x;
    logic [FIELD_W-1:0] cell_row;
    logic [FIELD_W-1:0] cell_col;
  } res_t;

  // blue -> green -> red ramp, t in 0..188
  function automatic logic [COLOR_W-1:0] ramp_color(logic [7:0] t);
    logic [15:0] tw;
    tw = {8'd0, t};
    if (t < 8'd64) begin
      return 16'd31 + (tw << 5);
    end else if (t < 8'd95) begin
      return 16'd2016 + (16'd94 - tw);
    end else if (t < 8'd126) begin
      return 16'd2016 + ((tw - 16'd94) << 11);
    end else begin
      return 16'd63488 + ((16'({8'd0, RAMP_SCALE}) - tw) << 5);
    end
  endfunction

endpackage

@@ hdl/crossing_grid_heatmap_redraw_top.sv @@
// Top level of the crossing grid heat map redraw block.
//
// Input stream: one word per sensor line update (line index and level, 65536 = 1.0).
// Indices below GRID_SIDE are columns, the next GRID_SIDE are rows; higher
// indices are accepted and dropped without effect.
// Output stream: one word per crossing cell whose color changes, with its
// grid position, circle center and RGB565 color; tlast marks the final
// word caused by one update. An update that changes nothing gives no word.
// Flow: an update walks its GRID_SIDE cells one per cycle, save while the
// sweep pauses for the output (below), through a three-stage pipeline
// (line read and cache read, ramp index, ramp and compare). The next
// update is taken after the sweep, once the pipeline is empty and the last
// word has moved to the output register; s_axis_tready is high only between
// updates. Each word leaves once the next changed cell or the end of the
// sweep is known.
// A stalled receiver holds the output word; with that word and one more
// pending, the sweep pauses at the next changed cell until the output
// register frees.
// Reset clears all line levels to zero and marks every cached color as the
// zero-level color; no clearing pass is needed.
module crossing_grid_heatmap_redraw_top #(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // line_index[4:0], level[22:5], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cell_col, cell_row, center_x, center_y, color
  output logic        m_axis_tlast   // last
);
  import cghr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  cghr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready)
  );

  cghr_dpath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .line_index_i (s_axis_tdata[IDX_W-1:0]),
    .level_i      (s_axis_tdata[IDX_W+LEVEL_W-1:IDX_W]),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .m_last_o     (m_axis_tlast),
    .m_res_o      (res)
  );

  assign m_axis_tdata = res;

endmodule

@@ hdl/cghr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cghr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cghr_ctrl.sv @@
// Sequencer: takes a line update, sweeps its cells, then drains the pipeline.
module cghr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  cghr_pkg::sts_t sts_i,
  output cghr_pkg::cmd_t cmd_o,
  output logic          s_ready_o
);
  import cghr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i && sts_i.in_range) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (sts_i.advance && sts_i.k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        if (sts_i.pipe_empty && !sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/cghr_dpath.sv @@
// Datapath: line levels, cell color cache, three-stage cell pipeline, output word.
module cghr_dpath #(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cghr_pkg::cmd_t                 cmd_i,
  output cghr_pkg::sts_t                 sts_o,
  input  logic [cghr_pkg::IDX_W-1:0]     line_index_i,
  input  logic signed [cghr_pkg::LEVEL_W-1:0] level_i,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic                           m_last_o,
  output cghr_pkg::res_t                 m_res_o
);
  import cghr_pkg::*;

  localparam int unsigned ColW  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned LineW = $clog2(2 * GRID_SIDE);
  localparam int unsigned CellW = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int unsigned Cells = GRID_SIDE * GRID_SIDE;

  // line store and current update
  logic signed [LEVEL_W-1:0] lines_q [2*GRID_SIDE];
  logic signed [LEVEL_W-1:0] cur_lvl_q;
  logic                      cur_is_col_q;
  logic [ColW-1:0]           cur_line_q;
  logic [ColW-1:0]           k_q;
  logic                      in_is_col;

  // cache valid bits
  logic [Cells-1:0] cvld_q;
  logic             vld_rd_q;
  logic [COLOR_W-1:0] ram_rdata;

  // stage 0 (issue)
  logic [ColW-1:0]  s0_col, s0_row;
  logic [LineW-1:0] s0_oth_idx;
  logic [CellW-1:0] s0_addr;
  logic             s0_fire;

  // stage 1
  logic                      s1_valid_q;
  logic [ColW-1:0]           s1_col_q, s1_row_q;
  logic [CellW-1:0]          s1_addr_q;
  logic signed [LEVEL_W-1:0] s1_oth_q;
  logic signed [LEVEL_W:0]   s1_sum;
  logic [24:0]               s1_prod;
  logic [7:0]                s1_t;

  // stage 2
  logic               s2_valid_q;
  logic [ColW-1:0]    s2_col_q, s2_row_q;
  logic [CellW-1:0]   s2_addr_q;
  logic [7:0]         s2_t_q;
  logic [COLOR_W-1:0] s2_cached_q;
  logic [COLOR_W-1:0] s2_color;
  logic               s2_changed;
  res_t               s2_res;
  logic [15:0]        s2_cx, s2_cy;

  // pending and output words
  logic pend_valid_q;
  res_t pend_q;
  logic m_valid_q, m_last_q;
  res_t m_res_q;

  logic out_free, advance, pipe_empty, move_mid, move_final;

  assign in_is_col = line_index_i < IDX_W'(GRID_SIDE);

  assign out_free   = !m_valid_q || m_ready_i;
  assign advance    = !(s2_changed && pend_valid_q && !out_free);
  assign pipe_empty = !s1_valid_q && !s2_valid_q;
  assign move_mid   = advance && s2_changed && pend_valid_q;
  assign move_final = cmd_i.drain && pipe_empty && pend_valid_q && out_free;
  assign s0_fire    = cmd_i.issue && advance;

  assign sts_o.in_range   = {1'b0, line_index_i} < (IDX_W + 1)'(2 * GRID_SIDE);
  assign sts_o.advance    = advance;
  assign sts_o.k_last     = k_q == ColW'(GRID_SIDE - 1);
  assign sts_o.pipe_empty = pipe_empty;
  assign sts_o.pend_valid = pend_valid_q;

  always_comb begin
    if (cur_is_col_q) begin
      s0_col     = cur_line_q;
      s0_row     = k_q;
      s0_oth_idx = LineW'(GRID_SIDE) + LineW'(k_q);
    end else begin
      s0_col     = k_q;
      s0_row     = cur_line_q;
      s0_oth_idx = LineW'(k_q);
    end
    s0_addr = CellW'(s0_col) * CellW'(GRID_SIDE) + CellW'(s0_row);
  end

  // ramp index: zero line forces zero, out-of-range average forces full scale
  always_comb begin
    s1_sum  = {cur_lvl_q[LEVEL_W-1], cur_lvl_q} + {s1_oth_q[LEVEL_W-1], s1_oth_q};
    s1_prod = 25'(s1_sum[LEVEL_W-1:0]) * 25'(RAMP_SCALE);
    if (cur_lvl_q == '0 || s1_oth_q == '0) begin
      s1_t = 8'd0;
    end else if (s1_sum < 0 || s1_sum > FULL_SUM) begin
      s1_t = RAMP_SCALE;
    end else begin
      s1_t = s1_prod[24:17];
    end
  end

  always_comb begin
    s2_color        = ramp_color(s2_t_q);
    s2_changed      = s2_valid_q && (s2_color != s2_cached_q);
    s2_cx           = (16'(s2_col_q) + 16'd1) * X_PITCH;
    s2_cy           = (16'(s2_row_q) + 16'd1) * Y_PITCH;
    s2_res.color    = s2_color;
    s2_res.center_x = s2_cx[COORD_W-1:0];
    s2_res.center_y = s2_cy[COORD_W-1:0];
    s2_res.cell_col = FIELD_W'(s2_col_q);
    s2_res.cell_row = FIELD_W'(s2_row_q);
  end

  cghr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (Cells)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (advance && s2_changed),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_color),
    .re_i    (s0_fire),
    .raddr_i (s0_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * GRID_SIDE; i++) begin
        lines_q[i] <= '0;
      end
      cvld_q       <= '0;
      k_q          <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lines_q[LineW'(line_index_i)] <= level_i;
        k_q <= '0;
      end else if (s0_fire) begin
        k_q <= k_q + ColW'(1);
      end
      if (advance) begin
        s1_valid_q <= s0_fire;
        s2_valid_q <= s1_valid_q;
      end
      if (advance && s2_changed) begin
        cvld_q[s2_addr_q] <= 1'b1;
        pend_valid_q      <= 1'b1;
      end else if (move_final) begin
        pend_valid_q <= 1'b0;
      end
      if (move_mid || move_final) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_lvl_q    <= level_i;
      cur_is_col_q <= in_is_col;
      cur_line_q   <= in_is_col ? ColW'(line_index_i)
                                : ColW'(line_index_i - IDX_W'(GRID_SIDE));
    end
    if (s0_fire) begin
      s1_col_q  <= s0_col;
      s1_row_q  <= s0_row;
      s1_addr_q <= s0_addr;
      s1_oth_q  <= lines_q[s0_oth_idx];
      vld_rd_q  <= cvld_q[s0_addr];
    end
    if (advance) begin
      s2_col_q    <= s1_col_q;
      s2_row_q    <= s1_row_q;
      s2_addr_q   <= s1_addr_q;
      s2_t_q      <= s1_t;
      s2_cached_q <= vld_rd_q ? ram_rdata : ZERO_COLOR;
    end
    if (advance && s2_changed) begin
      pend_q <= s2_res;
    end
    if (move_mid || move_final) begin
      m_res_q  <= pend_q;
      m_last_q <= move_final;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_last_o  = m_last_q;
  assign m_res_o   = m_res_q;

endmodule

@@ hdl/cghr_checker.sv @@
// Port-level checks of the heat map redraw block, bound to the top level.
`include "assert_macros.svh"

module cghr_checker #(
  parameter int unsigned GRID_SIDE = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic in_word, in_range;

  assign in_word  = s_axis_tvalid && s_axis_tready;
  assign in_range = {1'b0, s_axis_tdata[4:0]} < 6'(2 * GRID_SIDE);

  `CHK_ASSERT(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `CHK_ASSERT(drop_stays_ready, clk_i, rst_ni, in_word && !in_range |=> s_axis_tready)
  `CHK_ASSERT_MSG(update_busy, clk_i, rst_ni, in_word && in_range |=> !s_axis_tready, "update did not occupy the block")

endmodule

bind crossing_grid_heatmap_redraw_top cghr_checker #(.GRID_SIDE(GRID_SIDE)) u_cghr_checker (.*);

@@ dv/cghr_checker.sv @@
// Checker for the heat map redraw block: watches both streams, predicts redraw words, compares.
module cghr_scoreboard #(
  parameter int unsigned SIDE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // line_index[4:0], level[22:5], zero pad
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,  // cell_col, cell_row, center_x, center_y, color
  input  logic        m_axis_tlast,  // last
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cghr_pkg::*;

  typedef struct packed {
    logic [2:0]  cell_col;
    logic [2:0]  cell_row;
    logic [8:0]  center_x;
    logic [8:0]  center_y;
    logic [15:0] color;
    logic        last;
  } redraw_t;

  logic signed [17:0] line_level [2*SIDE];
  logic [15:0]        cell_cache [SIDE*SIDE];
  redraw_t            redraw_q [$];

  function automatic logic [15:0] ramp_rgb565(logic [7:0] t);
    logic [15:0] tw;
    tw = {8'd0, t};
    if (tw < 16'd64) return 16'd31 + (tw << 5);
    if (tw < 16'd95) return (16'd63 << 5) + (16'd94 - tw);
    if (tw < 16'd126) return (16'd63 << 5) + ((tw - 16'd94) << 11);
    return (16'd31 << 11) + ((16'd188 - tw) << 5);
  endfunction

  function automatic logic [15:0] crossing_color(logic signed [17:0] a, logic signed [17:0] b);
    logic signed [18:0] s;
    logic [31:0]        t;
    if (a == 0 || b == 0) return ramp_rgb565(8'd0);
    s = {a[17], a} + {b[17], b};
    if (s < 0 || s > 19'sd131072) t = 32'd188;
    else t = ({13'd0, s} * 32'd188) >> 17;
    return ramp_rgb565(t[7:0]);
  endfunction

  // store the line level, then sweep its cells and queue the ones that change color
  task automatic sweep_line(logic [4:0] idx, logic signed [17:0] lvl);
    redraw_t     hits [SIDE];
    int          n;
    int unsigned col;
    int unsigned row;
    logic [15:0] c;
    n = 0;
    if (idx >= 2 * SIDE) return;
    line_level[idx] = lvl;
    for (int k = 0; k < SIDE; k++) begin
      if (idx < SIDE) begin
        col = idx;
        row = k;
      end else begin
        col = k;
        row = idx - SIDE;
      end
      c = crossing_color(line_level[col], line_level[SIDE + row]);
      if (c != cell_cache[col * SIDE + row]) begin
        cell_cache[col * SIDE + row] = c;
        hits[n].cell_col = 3'(col);
        hits[n].cell_row = 3'(row);
        hits[n].center_x = 9'((col + 1) * 53);
        hits[n].center_y = 9'((row + 1) * 35);
        hits[n].color    = c;
        hits[n].last     = 1'b0;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      hits[i].last = (i == n - 1);
      redraw_q.push_back(hits[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    redraw_t want;
    redraw_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 2 * SIDE; i++) line_level[i] = '0;
      for (int i = 0; i < SIDE * SIDE; i++) cell_cache[i] = ZERO_COLOR;
      redraw_q.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
      pending_o  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sweep_line(s_axis_tdata[4:0], s_axis_tdata[22:5]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.cell_col = m_axis_tdata[2:0];
        got.cell_row = m_axis_tdata[5:3];
        got.center_x = m_axis_tdata[14:6];
        got.center_y = m_axis_tdata[23:15];
        got.color    = m_axis_tdata[39:24];
        got.last     = m_axis_tlast;
        if (redraw_q.size() == 0) begin
          $error("redraw word with none pending: col %0d row %0d color %0h",
                 got.cell_col, got.cell_row, got.color);
          fail_cnt_o++;
        end else begin
          want = redraw_q.pop_front();
          checked_o++;
          if (got.cell_col != want.cell_col) begin
            $error("cell_col: expected %0d, actual %0d", want.cell_col, got.cell_col);
            fail_cnt_o++;
          end
          if (got.cell_row != want.cell_row) begin
            $error("cell_row: expected %0d, actual %0d", want.cell_row, got.cell_row);
            fail_cnt_o++;
          end
          if (got.center_x != want.center_x) begin
            $error("center_x: expected %0d, actual %0d", want.center_x, got.center_x);
            fail_cnt_o++;
          end
          if (got.center_y != want.center_y) begin
            $error("center_y: expected %0d, actual %0d", want.center_y, got.center_y);
            fail_cnt_o++;
          end
          if (got.color != want.color) begin
            $error("color: expected %0h, actual %0h", want.color, got.color);
            fail_cnt_o++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_cnt_o++;
          end
        end
      end
      pending_o = redraw_q.size();
    end
  end

endmodule

@@ dv/crossing_grid_heatmap_redraw_top_test.sv @@
// Testbench top for the heat map redraw block: clock, reset, stimulus and verdict.
module crossing_grid_heatmap_redraw_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE         = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // line_index[4:0], level[22:5], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // cell_col, cell_row, center_x, center_y, color
  logic        m_axis_tlast;  // last

  int fail_cnt;
  int pending;
  int checked;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int n_lines     = 0;
  int n_ignored   = 0;

  always #1 clk_i = ~clk_i;

  crossing_grid_heatmap_redraw_top #(
    .GRID_SIDE(SIDE)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  cghr_scoreboard #(
    .SIDE(SIDE)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // offer one update word, optionally after a gap; returns at the falling edge after acceptance
  task automatic send_update(input logic [4:0] idx, input logic [17:0] lvl);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lvl, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (idx >= 2 * SIDE) n_ignored++;
    else n_lines++;
  endtask

  function automatic logic [17:0] rand_level();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return 18'd0;
    if (sel < 13) return 18'($urandom_range(1, 65536));
    if (sel < 15) return 18'($urandom_range(65536, 131071));
    return 18'($urandom());
  endfunction

  task automatic random_updates(input int count);
    logic [4:0] idx;
    int         n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 19) < 17) idx = 5'($urandom_range(0, 2 * SIDE - 1));
      else idx = 5'($urandom_range(2 * SIDE, 31));
      send_update(idx, rand_level());
      n++;
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // stall watchdog: cycles without any accepted word on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    int gap;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        gap = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int tb [6];
    int s;
    tb = '{63, 64, 94, 95, 125, 126};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero lines, extremes, ignored indices, ramp segment edges, clamp
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_update(5'd0, 18'd65536);        // row still zero: nothing changes
    send_update(5'd8, 18'd65536);        // sum exactly full scale
    send_update(5'd16, 18'h1ffff);       // out of range
    send_update(5'd31, 18'h20000);       // out of range
    send_update(5'd9, 18'd1);
    send_update(5'd10, 18'h3ffff);
    send_update(5'd11, 18'h1ffff);
    send_update(5'd12, 18'h20000);
    send_update(5'd13, 18'd32768);
    send_update(5'd14, 18'd65535);
    send_update(5'd15, 18'd98304);
    send_update(5'd0, 18'd0);            // whole column back to zero color
    send_update(5'd7, 18'h1ffff);
    for (int i = 0; i < 6; i++) begin
      s = (tb[i] * 131072 + 187) / 188;
      send_update(5'(i + 1), 18'(s - 65536));
    end
    send_update(5'd0, 18'd65537);        // just above full scale
    send_update(5'd0, 18'd65536);
    send_update(5'd8, 18'd0);            // whole row back to zero color

    // random phase with a long output stall at its start
    hold_req = 1'b1;
    random_updates(90);

    tx_idle_pct = 0;
    rx_idle_pct = 50;
    random_updates(90);

    // sender pauses until every redraw word is out
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk_i);

    tx_idle_pct = 50;
    rx_idle_pct = 0;
    random_updates(80);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_updates(80);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d line updates and %0d out-of-range words, %0d redraw words checked",
             n_lines, n_ignored, checked);
    $display("phases: directed edges, long output stall, idle bursts on each side, quiet tail");
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
